[rtl/hkrt_pkg.sv]
// ============================================================================
// hkrt_pkg - shared types and constants for the HID keyboard report tracker
// Request codes, the ASCII to usage table, the decoded operation carried
// from front to back, and the result beat layout.
// ============================================================================
package hkrt_pkg;

    // Default number of key slots (boot protocol 6KRO)
    localparam int KEY_SLOTS_DEFAULT = 6;
    // Number of slot ports on the result side
    localparam int NUM_SLOT_PORTS    = 6;

    // Operation queue between front and back
    localparam int OPQ_DEPTH = 2;
    localparam int OPQ_AW    = $clog2(OPQ_DEPTH);

    // Key code ranges and flags
    localparam logic [7:0] RAW_CODE_BASE = 8'd136;
    localparam logic [7:0] MOD_CODE_BASE = 8'd128;
    localparam logic [7:0] SHIFT_FLAG    = 8'h80;
    localparam logic [7:0] USAGE_MASK    = 8'h7F;
    localparam logic [7:0] LEFT_SHIFT    = 8'h02;

    typedef enum logic [3:0] {
        REQ_PRESS_KEY     = 4'd0,
        REQ_RELEASE_KEY   = 4'd1,
        REQ_PRESS_MEDIA   = 4'd2,
        REQ_RELEASE_MEDIA = 4'd3,
        REQ_RELEASE_ALL   = 4'd4,
        REQ_WRITE_KEY     = 4'd5,
        REQ_WRITE_MEDIA   = 4'd6,
        REQ_LINK_UP       = 4'd7,
        REQ_LINK_DOWN     = 4'd8
    } t_req;

    // Decoded request, as classified by the front
    typedef struct packed {
        t_req        req;
        logic        mapped;     // key code maps to something
        logic [7:0]  usage;      // usage code for the slots, 0 for none
        logic [7:0]  mod_mask;   // modifier bits, shift folded in
        logic [15:0] media_bits;
    } t_op;

    // One result beat
    typedef struct packed {
        logic                              accepted;
        logic                              report_sent;
        logic                              report_kind;
        logic [7:0]                        modifiers;
        logic [NUM_SLOT_PORTS-1:0][7:0]    slots;
        logic [15:0]                       media_state;
        logic                              last_of_run;
    } t_result;

    // ASCII to usage; bit 7 requests left shift, 0 means unmapped
    localparam logic [7:0] ASCII_TO_USAGE [128] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h2a,8'h2b,8'h28,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h2c,8'h9e,8'hb4,8'ha0,8'ha1,8'ha2,8'ha4,8'h34,
        8'ha6,8'ha7,8'ha5,8'hae,8'h36,8'h2d,8'h37,8'h38,
        8'h27,8'h1e,8'h1f,8'h20,8'h21,8'h22,8'h23,8'h24,
        8'h25,8'h26,8'hb3,8'h33,8'hb6,8'h2e,8'hb7,8'hb8,
        8'h9f,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,
        8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h91,8'h92,
        8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,
        8'h9b,8'h9c,8'h9d,8'h2f,8'h31,8'h30,8'ha3,8'had,
        8'h35,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,
        8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,
        8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1a,
        8'h1b,8'h1c,8'h1d,8'haf,8'hb1,8'hb0,8'hb5,8'h00
    };

endpackage

[rtl/hkrt_front.sv]
// ============================================================================
// hkrt_front - request classifier
// Maps the key code of an incoming beat to a usage code and modifier mask
// and packs the request into an operation for the queue.
// ============================================================================
module hkrt_front (
    input  logic [3:0]      i_req_type,
    input  logic [7:0]      i_key_code,
    input  logic [15:0]     i_media_bits,
    output hkrt_pkg::t_op   o_op
);
    import hkrt_pkg::*;

    logic [7:0] tbl_entry;

    assign tbl_entry = ASCII_TO_USAGE[i_key_code[6:0]];

    // Key code mapping: raw, modifier or ASCII
    always_comb begin
        o_op.req        = t_req'(i_req_type);
        o_op.media_bits = i_media_bits;
        o_op.mapped     = 1'b1;
        o_op.usage      = 8'h00;
        o_op.mod_mask   = 8'h00;
        if (i_key_code >= RAW_CODE_BASE) begin
            o_op.usage = i_key_code - RAW_CODE_BASE;
        end else if (i_key_code >= MOD_CODE_BASE) begin
            o_op.mod_mask = 8'h01 << i_key_code[2:0];
        end else begin
            o_op.mapped   = (tbl_entry != 8'h00);
            o_op.usage    = tbl_entry & USAGE_MASK;
            o_op.mod_mask = ((tbl_entry & SHIFT_FLAG) != 8'h00) ? LEFT_SHIFT : 8'h00;
        end
    end

endmodule

[rtl/hkrt_op_queue.sv]
// ============================================================================
// hkrt_op_queue - operation queue
// Short FIFO of decoded operations between the front and the back.
// ============================================================================
module hkrt_op_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hkrt_pkg::t_op   i_op,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output hkrt_pkg::t_op   o_op
);
    import hkrt_pkg::*;

    t_op                r_mem [OPQ_DEPTH];
    logic [OPQ_AW-1:0]  r_wr_ptr;
    logic [OPQ_AW-1:0]  r_rd_ptr;
    logic [OPQ_AW:0]    r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == OPQ_AW'(0) + (OPQ_AW+1)'(OPQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/hkrt_back.sv]
// ============================================================================
// hkrt_back - report state engine
// Holds the key slots, modifier byte, media mask and link flag and registers
// results; one op (or half a write) per cycle while no result waits unpopped.
// ============================================================================
module hkrt_back #(
    parameter int KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    input  hkrt_pkg::t_op       i_op,
    output logic                o_op_pop,
    output logic                o_res_valid,
    output hkrt_pkg::t_result   o_res,
    input  logic                i_res_pop
);
    import hkrt_pkg::*;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'b01,
        PH_SECOND = 2'b10
    } t_phase;

    logic [KEY_SLOTS-1:0][7:0] r_slots, n_slots;
    logic [7:0]                r_mods, n_mods;
    logic [15:0]               r_media, n_media;
    logic                      r_link, n_link;
    t_phase                    r_phase;
    logic                      r_res_valid;
    t_result                   r_res, n_res;

    logic fire;
    logic is_write;

    // Press candidate
    logic [KEY_SLOTS-1:0][7:0] p_slots;
    logic [7:0]                p_mods;
    logic                      p_found, p_placed, p_ok;

    // Release candidate
    logic [KEY_SLOTS-1:0][7:0] rl_slots;
    logic [7:0]                rl_mods;

    assign is_write = (i_op.req == REQ_WRITE_KEY) || (i_op.req == REQ_WRITE_MEDIA);
    assign fire     = i_op_valid && (!r_res_valid || i_res_pop);
    assign o_op_pop = fire && (!is_write || (r_phase == PH_SECOND));

    // Key press: reuse a matching slot or take the first empty one
    always_comb begin
        p_slots  = r_slots;
        p_found  = 1'b0;
        p_placed = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_slots[i] == i_op.usage) begin
                p_found = 1'b1;
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (i_op.mapped && !p_found && !p_placed && r_slots[i] == 8'h00) begin
                p_slots[i] = i_op.usage;
                p_placed   = 1'b1;
            end
        end
        p_ok   = i_op.mapped && (p_found || p_placed);
        p_mods = i_op.mapped ? (r_mods | i_op.mod_mask) : r_mods;
    end

    // Key release: clear modifier bits and matching nonzero slots
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            rl_slots[i] = (i_op.mapped && i_op.usage != 8'h00 && r_slots[i] == i_op.usage)
                        ? 8'h00 : r_slots[i];
        end
        rl_mods = i_op.mapped ? (r_mods & ~i_op.mod_mask) : r_mods;
    end

    // Operation select and next state
    always_comb begin
        n_slots = r_slots;
        n_mods  = r_mods;
        n_media = r_media;
        n_link  = r_link;
        n_res.accepted    = 1'b0;
        n_res.report_sent = 1'b0;
        n_res.report_kind = 1'b0;
        n_res.last_of_run = 1'b1;
        case (i_op.req)
            REQ_PRESS_KEY: begin
                n_slots = p_slots;
                n_mods  = p_mods;
                n_res.accepted    = p_ok;
                n_res.report_sent = p_ok && r_link;
            end
            REQ_RELEASE_KEY: begin
                n_slots = rl_slots;
                n_mods  = rl_mods;
                n_res.accepted    = i_op.mapped;
                n_res.report_sent = i_op.mapped && r_link;
            end
            REQ_WRITE_KEY: begin
                if (r_phase == PH_FIRST) begin
                    n_slots = p_slots;
                    n_mods  = p_mods;
                    n_res.accepted    = p_ok;
                    n_res.report_sent = p_ok && r_link;
                    n_res.last_of_run = 1'b0;
                end else begin
                    n_slots = rl_slots;
                    n_mods  = rl_mods;
                    n_res.accepted    = i_op.mapped;
                    n_res.report_sent = i_op.mapped && r_link;
                end
            end
            REQ_PRESS_MEDIA: begin
                n_media = r_media | i_op.media_bits;
                n_res.accepted    = 1'b1;
                n_res.report_sent = r_link;
                n_res.report_kind = 1'b1;
            end
            REQ_RELEASE_MEDIA: begin
                n_media = r_media & ~i_op.media_bits;
                n_res.accepted    = 1'b1;
                n_res.report_sent = r_link;
                n_res.report_kind = 1'b1;
            end
            REQ_WRITE_MEDIA: begin
                n_res.accepted    = 1'b1;
                n_res.report_sent = r_link;
                n_res.report_kind = 1'b1;
                if (r_phase == PH_FIRST) begin
                    n_media = r_media | i_op.media_bits;
                    n_res.last_of_run = 1'b0;
                end else begin
                    n_media = r_media & ~i_op.media_bits;
                end
            end
            REQ_RELEASE_ALL: begin
                n_slots = '0;
                n_mods  = 8'h00;
                n_media = 16'h0000;
                n_res.accepted    = 1'b1;
                n_res.report_sent = r_link;
            end
            REQ_LINK_UP: begin
                n_link = 1'b1;
                n_res.accepted = 1'b1;
            end
            REQ_LINK_DOWN: begin
                n_link = 1'b0;
                n_res.accepted = 1'b1;
            end
            default: begin
                n_res.accepted = 1'b0;
            end
        endcase
        n_res.modifiers   = n_mods;
        n_res.media_state = n_media;
        // Snapshot of the slots; ports beyond the slot count read zero
        for (int j = 0; j < NUM_SLOT_PORTS; j++) begin
            n_res.slots[j] = 8'h00;
        end
        for (int j = 0; j < KEY_SLOTS && j < NUM_SLOT_PORTS; j++) begin
            n_res.slots[j] = n_slots[j];
        end
    end

    // State and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots     <= '0;
            r_mods      <= 8'h00;
            r_media     <= 16'h0000;
            r_link      <= 1'b0;
            r_phase     <= PH_FIRST;
            r_res_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_slots <= n_slots;
                r_mods  <= n_mods;
                r_media <= n_media;
                r_link  <= n_link;
                if (is_write) begin
                    r_phase <= (r_phase == PH_FIRST) ? PH_SECOND : PH_FIRST;
                end
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Result register, no reset
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

[rtl/hid_keyboard_report_tracker.sv]
// Path: with both sides idle, a request beat accepted at one edge is written into
//   the operation queue and then into the result register; a write request's
//   second result beat follows at the edge that pops the first.
// Writes: the state engine carries out a write in two halves, press then release
//   (both halves share the one slot/modifier update path).
// Reset: synchronous, active low; clears slots, modifiers, media mask, link
//   flag, the operation queue and the result valid flag.
// ============================================================================
// hid_keyboard_report_tracker - HID boot keyboard 6KRO report builder
// Front classifies requests into a two-entry operation queue; the back
// updates the report state and presents result beats through a register.
// ============================================================================
module hid_keyboard_report_tracker #(
    parameter int KEY_SLOTS = hkrt_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  i_req_type,
    input  logic [7:0]  i_key_code,
    input  logic [15:0] i_media_bits,
    output logic        empty,
    input  logic        pop,
    output logic        o_accepted,
    output logic        o_report_sent,
    output logic        o_report_kind,
    output logic [7:0]  o_modifiers,
    output logic [7:0]  o_slot_0,
    output logic [7:0]  o_slot_1,
    output logic [7:0]  o_slot_2,
    output logic [7:0]  o_slot_3,
    output logic [7:0]  o_slot_4,
    output logic [7:0]  o_slot_5,
    output logic [15:0] o_media_state,
    output logic        o_last_of_run
);
    import hkrt_pkg::*;

    t_op     front_op;
    t_op     q_op;
    logic    q_valid;
    logic    q_pop;
    logic    res_valid;
    t_result res;

    // Front: classify request beat
    hkrt_front u_front (
        .i_req_type   (i_req_type),
        .i_key_code   (i_key_code),
        .i_media_bits (i_media_bits),
        .o_op         (front_op)
    );

    // Queue between front and back
    hkrt_op_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    // Back: report state and result register
    hkrt_back #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .i_op        (q_op),
        .o_op_pop    (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    assign empty         = !res_valid;
    assign o_accepted    = res.accepted;
    assign o_report_sent = res.report_sent;
    assign o_report_kind = res.report_kind;
    assign o_modifiers   = res.modifiers;
    assign o_slot_0      = res.slots[0];
    assign o_slot_1      = res.slots[1];
    assign o_slot_2      = res.slots[2];
    assign o_slot_3      = res.slots[3];
    assign o_slot_4      = res.slots[4];
    assign o_slot_5      = res.slots[5];
    assign o_media_state = res.media_state;
    assign o_last_of_run = res.last_of_run;

    // The back only takes an operation that the queue holds
    a_pop_needs_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("operation popped from empty queue");

    // A full queue always offers an operation to the back
    a_full_has_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> q_valid)
        else $error("queue full without a pending operation");

    // Reset leaves both sides idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full && !q_valid))
        else $error("block not idle after reset");

    // A first-half beat is never the last one, and is followed by its second half
    a_write_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last_of_run && pop) |=> (!empty || q_valid))
        else $error("write request lost its second result");

endmodule
